// ===== rtl/acr_pkg.sv =====
// ----------------------------------------------------------------------------
// acr_pkg
// Shared widths, item codes and the command type passed from the front end
// through the command queue to the pixel back end of the circle rasterizer.
// ----------------------------------------------------------------------------
package acr_pkg;

    localparam int COORD_BITS  = 13;
    localparam int RADIUS_BITS = 11;
    localparam int PIX_BITS    = 14;

    // decision variable range is about +-2r, plus sign
    localparam int DEC_BITS    = RADIUS_BITS + 3;
    // pixel sums are formed wide and then wrapped to PIX_BITS
    localparam int CALC_BITS   = COORD_BITS + RADIUS_BITS + 2;

    localparam int BEATS       = 8;
    localparam int BEAT_BITS   = $clog2(BEATS);
    localparam logic [BEAT_BITS-1:0] LAST_BEAT = BEAT_BITS'(BEATS - 1);

    localparam int Q_DEPTH     = 2;
    localparam int QPTR_BITS   = $clog2(Q_DEPTH);
    localparam int QCNT_BITS   = $clog2(Q_DEPTH + 1);

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [RADIUS_BITS-1:0] ofs_x_t;
    typedef logic signed [RADIUS_BITS:0]   ofs_y_t;
    typedef logic signed [DEC_BITS-1:0]    dec_t;
    typedef logic signed [PIX_BITS-1:0]    pix_t;

    typedef struct packed {
        logic   fin;
        coord_t cx;
        coord_t cy;
        ofs_x_t px;
        ofs_y_t py;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

endpackage

// ===== rtl/andres_circle_rasterizer.sv =====
// ----------------------------------------------------------------------------
// andres_circle_rasterizer
// Integer circle rasterizer: start beats load a circle, step beats give the
// eight mirrored pixels of the current offset and advance it, or one finished beat once done.
//
//   channel   dir   fields                                        handshake
//   s_*       in    kind, center_x, center_y, radius              valid/ready
//   m_*       out   pixel_x, pixel_y, last_of_step, finished      valid/ready
//
// a start beat gives no output beat
// a step beat gives eight output beats from the output register, one per cycle
// while m_ready is high; a finished step gives one beat
// a two-entry command queue lets the front take beats while pixels drain
// reset is synchronous, active low on aresetn; no circle is loaded after it
// s_ready drops only when the queue is full; m_ready low holds the output beat
// ----------------------------------------------------------------------------
module andres_circle_rasterizer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic signed [acr_pkg::COORD_BITS-1:0] s_center_x,
    input  logic signed [acr_pkg::COORD_BITS-1:0] s_center_y,
    input  logic [acr_pkg::RADIUS_BITS-1:0]       s_radius,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [acr_pkg::PIX_BITS-1:0]   m_pixel_x,
    output logic signed [acr_pkg::PIX_BITS-1:0]   m_pixel_y,
    output logic                m_last_of_step,
    output logic                m_finished
);

    acr_pkg::q_status_t q_status;
    acr_pkg::cmd_t      push_cmd;
    acr_pkg::cmd_t      head;
    logic               push;
    logic               pop;

    acr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_center_x (s_center_x),
        .s_center_y (s_center_y),
        .s_radius   (s_radius),
        .q_status   (q_status),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    acr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    acr_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (head),
        .q_status       (q_status),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_last_of_step (m_last_of_step),
        .m_finished     (m_finished)
    );

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_status.full)
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_status.valid)
        else $error("command popped from an empty queue");

    a_fin_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_finished) |->
            (m_last_of_step && (m_pixel_x == '0) && (m_pixel_y == '0)))
        else $error("finished beat not marked last or pixel not zero");

    a_start_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_kind == acr_pkg::KIND_START)) |-> !push)
        else $error("start beat produced a command");
`endif

endmodule

// ===== rtl/acr_front.sv =====
// ----------------------------------------------------------------------------
// acr_front
// Takes input beats, keeps the circle state and advances it by the Andres
// rule on every step until done; each step pushes one command into the queue.
// ----------------------------------------------------------------------------
module acr_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  acr_pkg::coord_t      s_center_x,
    input  acr_pkg::coord_t      s_center_y,
    input  logic [acr_pkg::RADIUS_BITS-1:0] s_radius,
    input  acr_pkg::q_status_t   q_status,
    output logic                 push,
    output acr_pkg::cmd_t        push_cmd
);

    localparam int RB = acr_pkg::RADIUS_BITS;
    localparam int DB = acr_pkg::DEC_BITS;

    acr_pkg::coord_t cx_reg, cx_next;
    acr_pkg::coord_t cy_reg, cy_next;
    logic [RB-1:0]   r_reg, r_next;
    acr_pkg::ofs_x_t px_reg, px_next;
    acr_pkg::ofs_y_t py_reg, py_next;
    acr_pkg::dec_t   d_reg, d_next;
    logic            active_reg, active_next;

    logic            accept;
    logic            done;
    logic signed [DB-1:0] px_s, py_s, r_s, px2, ry2;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && (s_kind == acr_pkg::KIND_STEP);

    assign px_s = {{(DB-RB){1'b0}}, px_reg};
    assign py_s = {{(DB-RB-1){py_reg[RB]}}, py_reg};
    assign r_s  = {{(DB-RB){1'b0}}, r_reg};
    assign px2  = px_s <<< 1;
    assign ry2  = (r_s - py_s) <<< 1;

    assign done = !active_reg || (py_s < px_s);

    always_comb begin
        push_cmd.fin = done;
        push_cmd.cx  = cx_reg;
        push_cmd.cy  = cy_reg;
        push_cmd.px  = px_reg;
        push_cmd.py  = py_reg;
    end

    always_comb begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        r_next      = r_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        d_next      = d_reg;
        active_next = active_reg;
        if (accept) begin
            if (s_kind == acr_pkg::KIND_START) begin
                cx_next     = s_center_x;
                cy_next     = s_center_y;
                r_next      = s_radius;
                px_next     = '0;
                py_next     = {1'b0, s_radius};
                d_next      = {{(DB-RB){1'b0}}, s_radius} - DB'(1);
                active_next = 1'b1;
            end else if (!done) begin
                if (d_reg >= px2) begin
                    d_next  = d_reg - px2 - DB'(1);
                    px_next = px_reg + RB'(1);
                end else if (d_reg < ry2) begin
                    d_next  = d_reg + (py_s <<< 1) - DB'(1);
                    py_next = py_reg - (RB+1)'(1);
                end else begin
                    d_next  = d_reg + ((py_s - px_s - DB'(1)) <<< 1);
                    py_next = py_reg - (RB+1)'(1);
                    px_next = px_reg + RB'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            r_reg      <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
            d_reg      <= '0;
            active_reg <= 1'b0;
        end else begin
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            r_reg      <= r_next;
            px_reg     <= px_next;
            py_reg     <= py_next;
            d_reg      <= d_next;
            active_reg <= active_next;
        end
    end

endmodule

// ===== rtl/acr_queue.sv =====
// ----------------------------------------------------------------------------
// acr_queue
// Two-entry command queue between the front end and the pixel back end.
// ----------------------------------------------------------------------------
module acr_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  acr_pkg::cmd_t       push_cmd,
    input  logic                pop,
    output acr_pkg::cmd_t       head,
    output acr_pkg::q_status_t  status
);

    acr_pkg::cmd_t mem [acr_pkg::Q_DEPTH];

    logic [acr_pkg::QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [acr_pkg::QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [acr_pkg::QCNT_BITS-1:0] count_reg, count_next;

    assign head         = mem[rd_ptr_reg];
    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == acr_pkg::QCNT_BITS'(acr_pkg::Q_DEPTH));

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + acr_pkg::QPTR_BITS'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + acr_pkg::QPTR_BITS'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + acr_pkg::QCNT_BITS'(1);
        end else if (pop && !push) begin
            count_next = count_reg - acr_pkg::QCNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/acr_back.sv =====
// ----------------------------------------------------------------------------
// acr_back
// Walks the eight octant mirrors of the queue head, one pixel per beat,
// into the output register; a finished command gives a single beat.
// ----------------------------------------------------------------------------
module acr_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  acr_pkg::cmd_t       head,
    input  acr_pkg::q_status_t  q_status,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output acr_pkg::pix_t       m_pixel_x,
    output acr_pkg::pix_t       m_pixel_y,
    output logic                m_last_of_step,
    output logic                m_finished
);

    localparam int CB = acr_pkg::CALC_BITS;
    localparam int KB = acr_pkg::COORD_BITS;
    localparam int RB = acr_pkg::RADIUS_BITS;
    localparam int PB = acr_pkg::PIX_BITS;

    logic [acr_pkg::BEAT_BITS-1:0] beat_reg, beat_next;
    logic                          valid_reg, valid_next;
    acr_pkg::pix_t                 x_reg, x_next;
    acr_pkg::pix_t                 y_reg, y_next;
    logic                          last_reg, last_next;
    logic                          fin_reg, fin_next;

    logic                 load;
    logic                 last_beat;
    logic signed [CB-1:0] cx_w, cy_w, px_w, py_w, a_w, b_w, x_w, y_w;

    assign load      = q_status.valid && (!valid_reg || m_ready);
    assign last_beat = head.fin || (beat_reg == acr_pkg::LAST_BEAT);
    assign pop       = load && last_beat;

    assign cx_w = {{(CB-KB){head.cx[KB-1]}}, head.cx};
    assign cy_w = {{(CB-KB){head.cy[KB-1]}}, head.cy};
    assign px_w = {{(CB-RB){1'b0}}, head.px};
    assign py_w = {{(CB-RB-1){head.py[RB]}}, head.py};

    // odd beats swap the roles of x and y offsets; bit 1 flips x, bit 2 flips y
    assign a_w = beat_reg[0] ? py_w : px_w;
    assign b_w = beat_reg[0] ? px_w : py_w;
    assign x_w = beat_reg[1] ? (cx_w - a_w) : (cx_w + a_w);
    assign y_w = beat_reg[2] ? (cy_w - b_w) : (cy_w + b_w);

    always_comb begin
        beat_next  = beat_reg;
        valid_next = valid_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        last_next  = last_reg;
        fin_next   = fin_reg;
        if (load) begin
            valid_next = 1'b1;
            last_next  = last_beat;
            fin_next   = head.fin;
            if (head.fin) begin
                x_next = '0;
                y_next = '0;
            end else begin
                x_next = x_w[PB-1:0];
                y_next = y_w[PB-1:0];
            end
            beat_next = last_beat ? '0 : beat_reg + acr_pkg::BEAT_BITS'(1);
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            beat_reg  <= beat_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        last_reg <= last_next;
        fin_reg  <= fin_next;
    end

    assign m_valid        = valid_reg;
    assign m_pixel_x      = x_reg;
    assign m_pixel_y      = y_reg;
    assign m_last_of_step = last_reg;
    assign m_finished     = fin_reg;

endmodule
